[rtl/mpce_pkg.sv]
`default_nettype none

package mpce_pkg;

	// Largest pixmap side; wider or taller settings saturate to this
	localparam int unsigned MAX_DIM = 320;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned COLOR_W = 16;
	localparam int unsigned DIM_W   = 9;
	localparam int unsigned COORD_W = 10;
	localparam int unsigned COUNT_W = 17;
	localparam int unsigned BIT_W   = 3;
	localparam int unsigned IDX_W   = 3;
	localparam int unsigned DATA_W  = 16;

	// Register indexes
	localparam logic [IDX_W-1:0] REG_FG_COLOR    = 3'd0;
	localparam logic [IDX_W-1:0] REG_BG_COLOR    = 3'd1;
	localparam logic [IDX_W-1:0] REG_INVERT      = 3'd2;
	localparam logic [IDX_W-1:0] REG_TRANSPARENT = 3'd3;
	localparam logic [IDX_W-1:0] REG_WIDTH       = 3'd4;
	localparam logic [IDX_W-1:0] REG_HEIGHT      = 3'd5;
	localparam logic [IDX_W-1:0] REG_ORIGIN_X    = 3'd6;
	localparam logic [IDX_W-1:0] REG_ORIGIN_Y    = 3'd7;

	// Settings and derived geometry handed to the expander
	typedef struct packed {
		logic [COLOR_W-1:0] fore_rgb;
		logic [COLOR_W-1:0] back_rgb;
		logic               invert_bits;
		logic               transparent_mode;
		logic [DIM_W-1:0]   origin_x;
		logic [DIM_W-1:0]   origin_y;
		logic [COORD_W-1:0] row_end;
		logic [COUNT_W-1:0] total_m1;
		logic               zero_total;
		logic               restart;
	} cfg_t;

endpackage

`default_nettype wire

[rtl/mpce_cfg.sv]
`default_nettype none

module mpce_cfg (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_wr_en,
	input  wire logic [mpce_pkg::IDX_W-1:0]  cfg_index,
	input  wire logic [mpce_pkg::DATA_W-1:0] cfg_wr_data,
	output mpce_pkg::cfg_t                   cfg
);

	logic [mpce_pkg::COLOR_W-1:0] fg_q;
	logic [mpce_pkg::COLOR_W-1:0] bg_q;
	logic                         invert_q;
	logic                         transp_q;
	logic [mpce_pkg::DIM_W-1:0]   width_q;
	logic [mpce_pkg::DIM_W-1:0]   height_q;
	logic [mpce_pkg::DIM_W-1:0]   origin_x_q;
	logic [mpce_pkg::DIM_W-1:0]   origin_y_q;
	logic [mpce_pkg::COORD_W-1:0] row_end_q;
	logic [mpce_pkg::COUNT_W-1:0] total_m1_q;
	logic                         zero_q;
	logic                         restart_q;
	logic [mpce_pkg::DIM_W-1:0]   dim_sat;
	logic [2*mpce_pkg::DIM_W-1:0] area;

	// Saturate a written dimension
	always_comb begin
		if (cfg_wr_data[mpce_pkg::DIM_W-1:0] > mpce_pkg::DIM_W'(mpce_pkg::MAX_DIM)) begin
			dim_sat = mpce_pkg::DIM_W'(mpce_pkg::MAX_DIM);
		end else begin
			dim_sat = cfg_wr_data[mpce_pkg::DIM_W-1:0];
		end
	end

	assign area = width_q * height_q;

	// Register file; geometry writes flag a restart
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_q       <= '1;
			bg_q       <= '0;
			invert_q   <= 1'b0;
			transp_q   <= 1'b0;
			width_q    <= mpce_pkg::DIM_W'(8);
			height_q   <= mpce_pkg::DIM_W'(8);
			origin_x_q <= '0;
			origin_y_q <= '0;
			restart_q  <= 1'b0;
		end else begin
			restart_q <= 1'b0;
			if (cfg_wr_en) begin
				unique case (cfg_index)
					mpce_pkg::REG_FG_COLOR:    fg_q <= cfg_wr_data[mpce_pkg::COLOR_W-1:0];
					mpce_pkg::REG_BG_COLOR:    bg_q <= cfg_wr_data[mpce_pkg::COLOR_W-1:0];
					mpce_pkg::REG_INVERT:      invert_q <= cfg_wr_data[0];
					mpce_pkg::REG_TRANSPARENT: transp_q <= cfg_wr_data[0];
					mpce_pkg::REG_WIDTH: begin
						width_q   <= dim_sat;
						restart_q <= 1'b1;
					end
					mpce_pkg::REG_HEIGHT: begin
						height_q  <= dim_sat;
						restart_q <= 1'b1;
					end
					mpce_pkg::REG_ORIGIN_X: begin
						origin_x_q <= cfg_wr_data[mpce_pkg::DIM_W-1:0];
						restart_q  <= 1'b1;
					end
					mpce_pkg::REG_ORIGIN_Y: begin
						origin_y_q <= cfg_wr_data[mpce_pkg::DIM_W-1:0];
						restart_q  <= 1'b1;
					end
					default: ;
				endcase
			end
		end
	end

	// Derived geometry, registered from the setting registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_m1_q <= mpce_pkg::COUNT_W'(63);
			row_end_q  <= mpce_pkg::COORD_W'(7);
			zero_q     <= 1'b0;
		end else begin
			total_m1_q <= mpce_pkg::COUNT_W'(area) - mpce_pkg::COUNT_W'(1);
			row_end_q  <= mpce_pkg::COORD_W'(origin_x_q) + mpce_pkg::COORD_W'(width_q)
			              - mpce_pkg::COORD_W'(1);
			zero_q     <= (width_q == '0) || (height_q == '0);
		end
	end

	always_comb begin
		cfg.fore_rgb         = fg_q;
		cfg.back_rgb         = bg_q;
		cfg.invert_bits      = invert_q;
		cfg.transparent_mode = transp_q;
		cfg.origin_x         = origin_x_q;
		cfg.origin_y         = origin_y_q;
		cfg.row_end          = row_end_q;
		cfg.total_m1         = total_m1_q;
		cfg.zero_total       = zero_q;
		cfg.restart          = restart_q;
	end

endmodule

`default_nettype wire

[rtl/mpce_expand.sv]
`default_nettype none

module mpce_expand (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire mpce_pkg::cfg_t               cfg,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [mpce_pkg::BYTE_W-1:0]  bit_byte,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [mpce_pkg::COORD_W-1:0]      pixel_x,
	output logic [mpce_pkg::COORD_W-1:0]      pixel_y,
	output logic [mpce_pkg::COLOR_W-1:0]      pixel_color,
	output logic                              run_last,
	output logic                              image_done
);

	// Byte under expansion
	logic                         work_v_q;
	logic [mpce_pkg::BYTE_W-1:0]  work_byte_q;
	logic [mpce_pkg::BIT_W-1:0]   bit_idx_q;

	// Pixmap position
	logic [mpce_pkg::COUNT_W-1:0] seen_q;
	logic [mpce_pkg::COORD_W-1:0] cursor_x_q;
	logic [mpce_pkg::COORD_W-1:0] cursor_y_q;

	// Result register
	logic                         out_v_q;
	logic [mpce_pkg::COORD_W-1:0] px_q;
	logic [mpce_pkg::COORD_W-1:0] py_q;
	logic [mpce_pkg::COLOR_W-1:0] pc_q;
	logic                         run_last_q;
	logic                         done_q;

	logic                         pix_bit;
	logic                         emit;
	logic                         last_pixel;
	logic                         out_free;
	logic                         step;
	logic                         fin;
	logic [mpce_pkg::COUNT_W-1:0] remain;
	logic [mpce_pkg::BIT_W-1:0]   ahead_max;
	logic [mpce_pkg::BYTE_W-1:0]  later;
	logic [mpce_pkg::BYTE_W-1:0]  live;
	logic                         end_of_run;
	logic [mpce_pkg::BIT_W:0]     span;

	// Current pixel
	assign pix_bit    = work_byte_q[bit_idx_q] ^ cfg.invert_bits;
	assign emit       = pix_bit || !cfg.transparent_mode;
	assign last_pixel = seen_q >= cfg.total_m1;
	assign out_free   = !out_v_q || out_ready;
	assign step       = work_v_q && !cfg.zero_total && (!emit || out_free);
	assign fin        = work_v_q && (cfg.zero_total ||
	                    (step && (last_pixel || bit_idx_q == '1)));
	assign in_ready   = !work_v_q || fin;

	// Does any later bit of this byte still give a result?
	assign remain    = cfg.total_m1 - seen_q;
	assign ahead_max = (remain > mpce_pkg::COUNT_W'(7)) ? '1 : remain[mpce_pkg::BIT_W-1:0];
	assign live      = cfg.transparent_mode
	                   ? (work_byte_q ^ {mpce_pkg::BYTE_W{cfg.invert_bits}}) : '1;

	always_comb begin
		later = '0;
		span  = '0;
		for (int j = 0; j < mpce_pkg::BYTE_W; j++) begin
			span     = 4'(j) - {1'b0, bit_idx_q};
			later[j] = (4'(j) > {1'b0, bit_idx_q}) && (span <= {1'b0, ahead_max});
		end
	end

	assign end_of_run = last_pixel || !(|(later & live));

	// Work register and position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			work_v_q   <= 1'b0;
			bit_idx_q  <= '0;
			seen_q     <= '0;
			cursor_x_q <= '0;
			cursor_y_q <= '0;
		end else begin
			if (in_valid && in_ready) begin
				work_v_q  <= 1'b1;
				bit_idx_q <= '0;
			end else if (fin) begin
				work_v_q <= 1'b0;
			end else if (step) begin
				bit_idx_q <= bit_idx_q + mpce_pkg::BIT_W'(1);
			end

			if (cfg.restart || (step && last_pixel)) begin
				seen_q     <= '0;
				cursor_x_q <= mpce_pkg::COORD_W'(cfg.origin_x);
				cursor_y_q <= mpce_pkg::COORD_W'(cfg.origin_y);
			end else if (step) begin
				seen_q <= seen_q + mpce_pkg::COUNT_W'(1);
				if (cursor_x_q >= cfg.row_end) begin
					cursor_x_q <= mpce_pkg::COORD_W'(cfg.origin_x);
					cursor_y_q <= cursor_y_q + mpce_pkg::COORD_W'(1);
				end else begin
					cursor_x_q <= cursor_x_q + mpce_pkg::COORD_W'(1);
				end
			end
		end
	end

	// Byte payload needs no reset
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			work_byte_q <= bit_byte;
		end
	end

	// Result register: valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (step && emit) begin
			out_v_q <= 1'b1;
		end else if (out_ready) begin
			out_v_q <= 1'b0;
		end
	end

	// Result register: payload
	always_ff @(posedge clk) begin
		if (step && emit) begin
			px_q       <= cursor_x_q;
			py_q       <= cursor_y_q;
			pc_q       <= pix_bit ? cfg.fore_rgb : cfg.back_rgb;
			run_last_q <= end_of_run;
			done_q     <= last_pixel;
		end
	end

	assign out_valid   = out_v_q;
	assign pixel_x     = px_q;
	assign pixel_y     = py_q;
	assign pixel_color = pc_q;
	assign run_last    = run_last_q;
	assign image_done  = done_q;

	// The pixel count never runs past the final pixel
	a_seen_range: assert property (@(posedge clk) disable iff (!arst_n)
		work_v_q && !cfg.zero_total |-> seen_q <= cfg.total_m1)
		else $error("pixel count beyond pixmap");

	// The final pixel always closes its byte's run
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && done_q |-> run_last_q)
		else $error("image_done without run_last");

	// A byte is only taken when none is held or the previous one is finishing
	a_accept_free: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> !work_v_q || fin)
		else $error("byte overwritten mid expansion");

	// A finished byte after its last pixel restarts at the origin
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		step && last_pixel |=> seen_q == '0)
		else $error("no restart after final pixel");

endmodule

`default_nettype wire

[rtl/mono_pixmap_color_expander.sv]
// A byte's transfer loads the work register; each pixel is then presented from the result register.
// Throughput: one pixel per cycle while out_ready keeps up; a byte's walk ends early when the
// pixmap's final pixel falls inside it, and an empty pixmap swallows the byte without a walk.
// The walk over the byte is bit-serial; the next byte is taken as its last bit steps.
// Reset (arst_n low) restores register defaults and puts the cursor at the origin.
`default_nettype none

module mono_pixmap_color_expander (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_wr_en,
	input  wire logic [mpce_pkg::IDX_W-1:0]   cfg_index,
	input  wire logic [mpce_pkg::DATA_W-1:0]  cfg_wr_data,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [mpce_pkg::BYTE_W-1:0]  bit_byte,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [mpce_pkg::COORD_W-1:0]      pixel_x,
	output logic [mpce_pkg::COORD_W-1:0]      pixel_y,
	output logic [mpce_pkg::COLOR_W-1:0]      pixel_color,
	output logic                              run_last,
	output logic                              image_done
);

	mpce_pkg::cfg_t cfg;

	// Settings
	mpce_cfg u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_wr_data (cfg_wr_data),
		.cfg         (cfg)
	);

	// Bit walk and result register
	mpce_expand u_expand (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.bit_byte    (bit_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.pixel_color (pixel_color),
		.run_last    (run_last),
		.image_done  (image_done)
	);

endmodule

`default_nettype wire

[dv/tb_mono_pixmap_color_expander.sv]
`default_nettype none

module tb_mono_pixmap_color_expander;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned SETTLE_CYCLES = 12;   // one byte walk plus margin
	localparam int unsigned STALL_LIMIT   = 4000; // cycles with no transfer at all
	localparam int unsigned GAP_MAX       = 18;
	localparam int unsigned HOLD_CYCLES   = 300;
	localparam int unsigned REPORT_MAX    = 10;

	typedef struct packed {
		logic [mpce_pkg::COORD_W-1:0] x;
		logic [mpce_pkg::COORD_W-1:0] y;
		logic [mpce_pkg::COLOR_W-1:0] color;
		logic                         run_last;
		logic                         image_done;
	} pixel_t;

	logic                          clk         = 1'b0;
	logic                          arst_n      = 1'b0;
	logic                          cfg_wr_en   = 1'b0;
	logic [mpce_pkg::IDX_W-1:0]    cfg_index   = '0;
	logic [mpce_pkg::DATA_W-1:0]   cfg_wr_data = '0;
	logic                          in_valid    = 1'b0;
	logic                          in_ready;
	logic [mpce_pkg::BYTE_W-1:0]   bit_byte    = '0;
	logic                          out_valid;
	logic                          out_ready   = 1'b0;
	logic [mpce_pkg::COORD_W-1:0]  pixel_x;
	logic [mpce_pkg::COORD_W-1:0]  pixel_y;
	logic [mpce_pkg::COLOR_W-1:0]  pixel_color;
	logic                          run_last;
	logic                          image_done;

	// Shadow of the block's registers and walk state
	logic [mpce_pkg::COLOR_W-1:0]  shadow_fg       = 16'hFFFF;
	logic [mpce_pkg::COLOR_W-1:0]  shadow_bg       = '0;
	logic                          shadow_invert   = 1'b0;
	logic                          shadow_transp   = 1'b0;
	logic [mpce_pkg::DIM_W-1:0]    shadow_width    = 9'd8;
	logic [mpce_pkg::DIM_W-1:0]    shadow_height   = 9'd8;
	logic [mpce_pkg::DIM_W-1:0]    shadow_org_x    = '0;
	logic [mpce_pkg::DIM_W-1:0]    shadow_org_y    = '0;
	logic [mpce_pkg::COUNT_W-1:0]  shadow_seen     = '0;
	logic [mpce_pkg::COORD_W-1:0]  shadow_cur_x    = '0;
	logic [mpce_pkg::COORD_W-1:0]  shadow_cur_y    = '0;

	pixel_t      pending_pixels[$];
	int unsigned errors        = 0;
	int unsigned bytes_sent    = 0;
	int unsigned pixels_seen   = 0;
	int unsigned images_closed = 0;
	int unsigned idle_cycles   = 0;
	int unsigned rx_hold       = 0;
	bit          tx_burst      = 1'b0;
	bit          rx_burst      = 1'b0;

	mono_pixmap_color_expander dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.bit_byte    (bit_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.pixel_color (pixel_color),
		.run_last    (run_last),
		.image_done  (image_done)
	);

	always #1 clk = ~clk;

	// Pixel count of the current pixmap, sides saturated
	function automatic int unsigned pixmap_area();
		int unsigned w;
		int unsigned h;
		w = (shadow_width > mpce_pkg::MAX_DIM) ? mpce_pkg::MAX_DIM : shadow_width;
		h = (shadow_height > mpce_pkg::MAX_DIM) ? mpce_pkg::MAX_DIM : shadow_height;
		return w * h;
	endfunction

	function automatic void home_cursor();
		shadow_seen  = '0;
		shadow_cur_x = {1'b0, shadow_org_x};
		shadow_cur_y = {1'b0, shadow_org_y};
	endfunction

	// Walk one byte's bits and queue the pixels it paints
	function automatic void expand_byte(input logic [mpce_pkg::BYTE_W-1:0] b);
		int unsigned w;
		int unsigned total;
		int          i;
		logic        bit_v;
		logic        last;
		pixel_t      px;
		pixel_t      run[$];
		w     = (shadow_width > mpce_pkg::MAX_DIM) ? mpce_pkg::MAX_DIM : shadow_width;
		total = pixmap_area();
		if (total == 0)
			return;
		for (i = 0; i < mpce_pkg::BYTE_W; i++) begin
			bit_v = b[i] ^ shadow_invert;
			last  = (int'(shadow_seen) + 1 >= total);
			if (bit_v || !shadow_transp) begin
				px.x          = shadow_cur_x;
				px.y          = shadow_cur_y;
				px.color      = bit_v ? shadow_fg : shadow_bg;
				px.run_last   = 1'b0;
				px.image_done = last;
				run.push_back(px);
			end
			if (last) begin
				home_cursor();
				break;
			end
			shadow_seen++;
			if (shadow_cur_x >= mpce_pkg::COORD_W'(int'(shadow_org_x) + w - 1)) begin
				shadow_cur_x = {1'b0, shadow_org_x};
				shadow_cur_y = shadow_cur_y + 1'b1;
			end else begin
				shadow_cur_x = shadow_cur_x + 1'b1;
			end
		end
		if (run.size() != 0)
			run[run.size()-1].run_last = 1'b1;
		foreach (run[k])
			pending_pixels.push_back(run[k]);
	endfunction

	// Register write; caller drops cfg_wr_en after its last write
	task automatic write_reg(input logic [mpce_pkg::IDX_W-1:0] idx,
			input logic [mpce_pkg::DATA_W-1:0] data);
		cfg_wr_en   <= 1'b1;
		cfg_index   <= idx;
		cfg_wr_data <= data;
		@(posedge clk);
		case (idx)
			mpce_pkg::REG_FG_COLOR:    shadow_fg     = data;
			mpce_pkg::REG_BG_COLOR:    shadow_bg     = data;
			mpce_pkg::REG_INVERT:      shadow_invert = data[0];
			mpce_pkg::REG_TRANSPARENT: shadow_transp = data[0];
			mpce_pkg::REG_WIDTH: begin
				shadow_width = data[mpce_pkg::DIM_W-1:0];
				home_cursor();
			end
			mpce_pkg::REG_HEIGHT: begin
				shadow_height = data[mpce_pkg::DIM_W-1:0];
				home_cursor();
			end
			mpce_pkg::REG_ORIGIN_X: begin
				shadow_org_x = data[mpce_pkg::DIM_W-1:0];
				home_cursor();
			end
			mpce_pkg::REG_ORIGIN_Y: begin
				shadow_org_y = data[mpce_pkg::DIM_W-1:0];
				home_cursor();
			end
			default: ;
		endcase
	endtask

	// Offer one byte; valid is left high so back-to-back bytes need no dip
	task automatic send_byte(input logic [mpce_pkg::BYTE_W-1:0] b);
		int unsigned gap;
		gap = tx_burst ? 0 : $urandom_range(0, GAP_MAX);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		bit_byte <= b;
		do @(posedge clk); while (in_ready !== 1'b1);
		expand_byte(b);
		bytes_sent++;
	endtask

	// Stop offering, let every pixel out, then let a silent byte finish
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [mpce_pkg::BYTE_W-1:0] pick_byte();
		case ($urandom_range(0, 7))
			0:       return 8'h00;
			1:       return 8'hFF;
			2:       return mpce_pkg::BYTE_W'($urandom) & mpce_pkg::BYTE_W'($urandom);
			default: return mpce_pkg::BYTE_W'($urandom);
		endcase
	endfunction

	// Register defaults: 8x8 opaque pixmap, white on black
	task automatic test_reset_defaults();
		logic [mpce_pkg::BYTE_W-1:0] seq[8];
		seq = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'hAA, 8'h55, 8'h00, 8'h00};
		seq[6] = mpce_pkg::BYTE_W'($urandom);
		seq[7] = mpce_pkg::BYTE_W'($urandom);
		foreach (seq[i])
			send_byte(seq[i]);
		drain();
	endtask

	// Transparent, inverted and opaque walks over a 3x3 pixmap; trailing bits dropped
	task automatic test_colour_modes();
		write_reg(mpce_pkg::REG_FG_COLOR, 16'h0000);
		write_reg(mpce_pkg::REG_BG_COLOR, 16'hFFFF);
		write_reg(mpce_pkg::REG_WIDTH, 16'd3);
		write_reg(mpce_pkg::REG_HEIGHT, 16'd3);
		write_reg(mpce_pkg::REG_TRANSPARENT, 16'd1);
		cfg_wr_en <= 1'b0;
		send_byte(8'hFF);
		send_byte(8'hFF);
		drain();
		write_reg(mpce_pkg::REG_INVERT, 16'd1);
		cfg_wr_en <= 1'b0;
		send_byte(8'h00);
		send_byte(8'hFE);
		send_byte(8'hFF);   // all clear after inversion: nothing painted
		drain();
		write_reg(mpce_pkg::REG_TRANSPARENT, 16'd0);
		cfg_wr_en <= 1'b0;
		send_byte(8'h5A);
		drain();
	endtask

	// Zero width, then zero height: bytes swallowed without output; then a 4x1 pixmap
	task automatic test_empty_pixmap();
		write_reg(mpce_pkg::REG_INVERT, 16'd0);
		write_reg(mpce_pkg::REG_WIDTH, 16'd0);
		cfg_wr_en <= 1'b0;
		repeat (3) send_byte(mpce_pkg::BYTE_W'($urandom));
		drain();
		write_reg(mpce_pkg::REG_WIDTH, 16'd4);
		write_reg(mpce_pkg::REG_HEIGHT, 16'd0);
		cfg_wr_en <= 1'b0;
		repeat (2) send_byte(mpce_pkg::BYTE_W'($urandom));
		drain();
		write_reg(mpce_pkg::REG_HEIGHT, 16'd1);
		cfg_wr_en <= 1'b0;
		send_byte(8'hC3);
		drain();
	endtask

	// Far origin, then a mid-pixmap origin change restarts the walk
	task automatic test_origin_restart();
		write_reg(mpce_pkg::REG_ORIGIN_X, 16'h01FF);
		write_reg(mpce_pkg::REG_ORIGIN_Y, 16'h01FF);
		write_reg(mpce_pkg::REG_WIDTH, 16'd5);
		write_reg(mpce_pkg::REG_HEIGHT, 16'd3);
		cfg_wr_en <= 1'b0;
		send_byte(8'h96);
		drain();
		write_reg(mpce_pkg::REG_ORIGIN_X, 16'd0);
		cfg_wr_en <= 1'b0;
		send_byte(8'h3C);
		send_byte(8'hE7);
		drain();
	endtask

	// Oversized sides clamp: a 320-wide row wraps, a 320-tall column ends
	task automatic test_saturated_geometry();
		write_reg(mpce_pkg::REG_WIDTH, 16'hFFFF);
		write_reg(mpce_pkg::REG_HEIGHT, 16'd2);
		write_reg(mpce_pkg::REG_ORIGIN_X, 16'h01FF);
		write_reg(mpce_pkg::REG_TRANSPARENT, 16'd1);
		cfg_wr_en <= 1'b0;
		tx_burst = 1'b0;
		repeat (42) send_byte(mpce_pkg::BYTE_W'($urandom) & mpce_pkg::BYTE_W'($urandom));
		drain();
		write_reg(mpce_pkg::REG_WIDTH, 16'd1);
		write_reg(mpce_pkg::REG_HEIGHT, 16'h01FF);
		write_reg(mpce_pkg::REG_ORIGIN_X, 16'd7);
		write_reg(mpce_pkg::REG_TRANSPARENT, 16'd0);
		cfg_wr_en <= 1'b0;
		repeat (40) send_byte(mpce_pkg::BYTE_W'($urandom));
		drain();
	endtask

	// Receiver holds off while bytes keep coming, so the input stalls
	task automatic test_output_stall();
		write_reg(mpce_pkg::REG_WIDTH, 16'd8);
		write_reg(mpce_pkg::REG_HEIGHT, 16'd8);
		cfg_wr_en <= 1'b0;
		tx_burst = 1'b1;
		rx_hold  = HOLD_CYCLES;
		repeat (16) send_byte(mpce_pkg::BYTE_W'($urandom));
		tx_burst = 1'b0;
		drain();
	endtask

	// Random settings, then mostly whole pixmaps with random content
	task automatic test_random_pixmaps(input int unsigned n_items);
		int unsigned                  sent;
		int unsigned                  area;
		int unsigned                  nbytes;
		logic [mpce_pkg::DATA_W-1:0]  data;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(0, 1)) begin
				case ($urandom_range(0, 3))
					0:       data = 16'h0000;
					1:       data = 16'hFFFF;
					default: data = mpce_pkg::DATA_W'($urandom);
				endcase
				write_reg(mpce_pkg::REG_FG_COLOR, data);
			end
			if ($urandom_range(0, 1))
				write_reg(mpce_pkg::REG_BG_COLOR, mpce_pkg::DATA_W'($urandom));
			if ($urandom_range(0, 1))
				write_reg(mpce_pkg::REG_INVERT, mpce_pkg::DATA_W'($urandom));
			if ($urandom_range(0, 1))
				write_reg(mpce_pkg::REG_TRANSPARENT, mpce_pkg::DATA_W'($urandom));
			if ($urandom_range(0, 3) != 0) begin
				case ($urandom_range(0, 15))
					0:       data = 16'd0;
					1:       data = mpce_pkg::DATA_W'($urandom);
					default: data = mpce_pkg::DATA_W'($urandom_range(1, 12));
				endcase
				write_reg(mpce_pkg::REG_WIDTH, data);
				case ($urandom_range(0, 15))
					0:       data = 16'd0;
					1:       data = mpce_pkg::DATA_W'($urandom);
					default: data = mpce_pkg::DATA_W'($urandom_range(1, 6));
				endcase
				write_reg(mpce_pkg::REG_HEIGHT, data);
				if ($urandom_range(0, 1))
					write_reg(mpce_pkg::REG_ORIGIN_X,
						mpce_pkg::DATA_W'($urandom_range(0, 511)));
				if ($urandom_range(0, 1))
					write_reg(mpce_pkg::REG_ORIGIN_Y, mpce_pkg::DATA_W'($urandom));
			end
			cfg_wr_en <= 1'b0;

			area   = pixmap_area();
			nbytes = (area == 0) ? $urandom_range(1, 3) : (area + 7) / 8;
			if (nbytes > 12)
				nbytes = 12;
			case ($urandom_range(0, 9))
				0:       nbytes = $urandom_range(1, nbytes);   // cut short
				1:       nbytes = nbytes + $urandom_range(1, 3);
				default: ;
			endcase
			tx_burst = ($urandom_range(0, 3) == 0);
			repeat (nbytes) send_byte(pick_byte());
			sent += nbytes;
			drain();
		end
		tx_burst = 1'b0;
	endtask

	// Pixel receiver and checker
	initial begin : pixel_checker
		int unsigned gap;
		pixel_t      got;
		pixel_t      want;
		wait (arst_n === 1'b1);
		forever begin
			if ($urandom_range(0, 31) == 0)
				rx_burst = !rx_burst;
			if (rx_hold != 0) begin
				gap     = rx_hold;
				rx_hold = 0;
			end else begin
				gap = rx_burst ? 0 : $urandom_range(0, GAP_MAX);
			end
			if (gap != 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (out_valid !== 1'b1);
			got = '{x: pixel_x, y: pixel_y, color: pixel_color,
				run_last: run_last, image_done: image_done};
			pixels_seen++;
			if (got.image_done)
				images_closed++;
			if (pending_pixels.size() == 0) begin
				errors++;
				if (errors <= REPORT_MAX)
					$display("%0t: pixel with nothing expected: x=%0d y=%0d colour=%h",
						$realtime, got.x, got.y, got.color);
			end else begin
				want = pending_pixels.pop_front();
				if (got.x !== want.x || got.y !== want.y || got.color !== want.color ||
						got.run_last !== want.run_last ||
						got.image_done !== want.image_done) begin
					errors++;
					if (errors <= REPORT_MAX)
						$display({"%0t: pixel mismatch: exp x=%0d y=%0d colour=%h last=%b ",
							"done=%b, got x=%0d y=%0d colour=%h last=%b done=%b"},
							$realtime, want.x, want.y, want.color, want.run_last,
							want.image_done, got.x, got.y, got.color, got.run_last,
							got.image_done);
				end
			end
		end
	end

	// Watchdog: ends the run if neither channel moves for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t: no transfer for %0d cycles, %0d pixels outstanding",
				$realtime, STALL_LIMIT, pending_pixels.size());
			$display("tb_mono_pixmap_color_expander: done, errors");
			$finish;
		end
	end

	initial begin : sequencer
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_colour_modes();
		test_empty_pixmap();
		test_origin_restart();
		test_output_stall();
		test_saturated_geometry();
		test_random_pixmaps(110);

		if (pending_pixels.size() != 0) begin
			$display("%0d expected pixels never arrived", pending_pixels.size());
			errors += pending_pixels.size();
		end
		$display("Sent %0d pixmap bytes, checked %0d pixels, %0d pixmaps completed.",
			bytes_sent, pixels_seen, images_closed);
		$display("Opaque, transparent, inverted, empty, clamped and restarted pixmaps; %0d errors.",
			errors);
		if (errors == 0)
			$display("tb_mono_pixmap_color_expander: done, clean");
		else
			$display("tb_mono_pixmap_color_expander: done, errors");
		$finish;
	end

endmodule

`default_nettype wire
